/* hdl/fcsc_pkg.sv */
// Package for the fan curve slew controller.
// Transaction, context and configuration types, curve and limit constants.
// No dependencies.
package fcsc_pkg;

   // One fan poll transaction as it enters the block
   typedef struct packed {
      logic [3:0]         fan_index;
      logic signed [15:0] temperature;
      logic               temperature_ok;
      logic [16:0]        fan_min_rpm;
      logic               fan_min_ok;
      logic [16:0]        fan_max_rpm;
      logic               fan_max_ok;
      logic               end_of_poll;
   } item_type;

   // Transaction plus the speed limits in use, carried down the curve pipeline
   typedef struct packed {
      item_type    item;
      logic [16:0] lo;
      logic [16:0] hi;
   } ctx_type;

   typedef struct packed {
      logic [16:0]        base_rpm;
      logic [16:0]        fallback_min_rpm;
      logic [16:0]        fallback_max_rpm;
      logic [11:0]        hold_band;
      logic [11:0]        drop_step_cool;
      logic [11:0]        drop_step_warm;
      logic signed [15:0] drop_switch_temp;
   } cfg_type;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_BASE_RPM         = 3'd0;
   localparam logic [2:0] CSR_FALLBACK_MIN_RPM = 3'd1;
   localparam logic [2:0] CSR_FALLBACK_MAX_RPM = 3'd2;
   localparam logic [2:0] CSR_HOLD_BAND        = 3'd3;
   localparam logic [2:0] CSR_DROP_STEP_COOL   = 3'd4;
   localparam logic [2:0] CSR_DROP_STEP_WARM   = 3'd5;
   localparam logic [2:0] CSR_DROP_SWITCH_TEMP = 3'd6;

   // Curve breakpoints, signed 8.8 degrees C: 55, 60, 70, 80, 90
   localparam logic signed [15:0] CURVE_T0 = 16'sd14080;
   localparam logic signed [15:0] CURVE_T1 = 16'sd15360;
   localparam logic signed [15:0] CURVE_T2 = 16'sd17920;
   localparam logic signed [15:0] CURVE_T3 = 16'sd20480;
   localparam logic signed [15:0] CURVE_T4 = 16'sd23040;

   // Intermediate points: max(base + add, floor), quarter rpm
   localparam logic [17:0] RP1_ADD   = 18'd600;
   localparam logic [17:0] RP1_FLOOR = 18'd7600;
   localparam logic [17:0] RP2_ADD   = 18'd2000;
   localparam logic [17:0] RP2_FLOOR = 18'd9200;
   localparam logic [17:0] RP3_ADD   = 18'd4000;
   localparam logic [17:0] RP3_FLOOR = 18'd12000;

   // Rounding offsets: half of the 1280 and 2560 segment widths
   localparam logic [29:0] HALF_NARROW = 30'd640;
   localparam logic [29:0] HALF_WIDE   = 30'd1280;

   // Divide by 5 via reciprocal: floor(2^22 / 5), then one correction step
   localparam int          RECIP_SHIFT = 22;
   localparam logic [19:0] RECIP_FIVE  = 20'd838860;

   localparam logic [16:0] REJECT_ABOVE = 17'd80000;
   localparam logic [3:0]  PHASE_LAST   = 4'd11;

   localparam logic [16:0] RST_BASE_RPM         = 17'd7000;
   localparam logic [16:0] RST_FALLBACK_MIN_RPM = 17'd4800;
   localparam logic [16:0] RST_FALLBACK_MAX_RPM = 17'd18000;
   localparam logic [11:0] RST_HOLD_BAND        = 12'd160;
   localparam logic [11:0] RST_DROP_STEP_COOL   = 12'd720;
   localparam logic [11:0] RST_DROP_STEP_WARM   = 12'd360;
   localparam logic [15:0] RST_DROP_SWITCH_TEMP = 16'd14848;

endpackage

/* hdl/fcsc_curve.sv */
// Seven-stage pipeline: speed limits, curve segment select, interpolation
// multiply, rounded divide by the segment width, clamp. Uses fcsc_pkg.
// Holds no per-fan state; stalls stage by stage from the out side.
module fcsc_curve (
   input  logic               clock,
   input  logic               reset,
   input  fcsc_pkg::cfg_type  cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  fcsc_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output fcsc_pkg::ctx_type  out_ctx,
   output logic [16:0]        out_desired
);

   // stage valids and stage-ready chain
   logic a_v_ff, b_v_ff, c_v_ff, d_v_ff, e_v_ff, f_v_ff, g_v_ff;
   logic a_rdy, b_rdy, c_rdy, d_rdy, e_rdy, f_rdy, g_rdy;

   assign g_rdy = !g_v_ff || out_ready;
   assign f_rdy = !f_v_ff || g_rdy;
   assign e_rdy = !e_v_ff || f_rdy;
   assign d_rdy = !d_v_ff || e_rdy;
   assign c_rdy = !c_v_ff || d_rdy;
   assign b_rdy = !b_v_ff || c_rdy;
   assign a_rdy = !a_v_ff || b_rdy;
   assign in_ready = a_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
         g_v_ff <= 1'b0;
      end else begin
         if (a_rdy) a_v_ff <= in_valid;
         if (b_rdy) b_v_ff <= a_v_ff;
         if (c_rdy) c_v_ff <= b_v_ff;
         if (d_rdy) d_v_ff <= c_v_ff;
         if (e_rdy) e_v_ff <= d_v_ff;
         if (f_rdy) f_v_ff <= e_v_ff;
         if (g_rdy) g_v_ff <= f_v_ff;
      end
   end

   // ---------------- stage A: limits and base point
   fcsc_pkg::ctx_type a_ctx_in, a_ctx_ff;
   logic [16:0]       a_b_in, a_b_ff;

   always_comb begin
      a_ctx_in.item = in_item;
      a_ctx_in.lo   = in_item.fan_min_ok ? in_item.fan_min_rpm : cfg.fallback_min_rpm;
      a_ctx_in.hi   = (in_item.fan_max_ok && (in_item.fan_max_rpm >= a_ctx_in.lo)) ?
                      in_item.fan_max_rpm : cfg.fallback_max_rpm;
      a_b_in        = (cfg.base_rpm > a_ctx_in.lo) ? cfg.base_rpm : a_ctx_in.lo;
   end

   always_ff @(posedge clock) begin
      if (a_rdy) begin
         a_ctx_ff <= a_ctx_in;
         a_b_ff   <= a_b_in;
      end
   end

   // ---------------- stage B: segment select
   fcsc_pkg::ctx_type  b_ctx_ff;
   logic [17:0]        b18, hi18, s1, s2, s3, rp1, rp2, rp3, r0_sel, r1_sel;
   logic signed [15:0] t, t_start, t_diff;
   logic               wide_sel, flat_sel;
   logic [11:0]        b_dt_in, b_dt_ff;
   logic signed [18:0] b_dr_in, b_dr_ff;
   logic [17:0]        b_r0_ff;
   logic               b_wide_ff;

   always_comb begin
      b18  = {1'b0, a_b_ff};
      hi18 = {1'b0, a_ctx_ff.hi};
      s1   = b18 + fcsc_pkg::RP1_ADD;
      s2   = b18 + fcsc_pkg::RP2_ADD;
      s3   = b18 + fcsc_pkg::RP3_ADD;
      rp1  = (s1 > fcsc_pkg::RP1_FLOOR) ? s1 : fcsc_pkg::RP1_FLOOR;
      rp2  = (s2 > fcsc_pkg::RP2_FLOOR) ? s2 : fcsc_pkg::RP2_FLOOR;
      rp3  = (s3 > fcsc_pkg::RP3_FLOOR) ? s3 : fcsc_pkg::RP3_FLOOR;
      t    = a_ctx_ff.item.temperature;

      t_start  = fcsc_pkg::CURVE_T0;
      r0_sel   = b18;
      r1_sel   = b18;
      wide_sel = 1'b0;
      flat_sel = 1'b1;
      if (t <= fcsc_pkg::CURVE_T0) begin
         r0_sel = b18;
         r1_sel = b18;
      end else if (t <= fcsc_pkg::CURVE_T1) begin
         t_start  = fcsc_pkg::CURVE_T0;
         r0_sel   = b18;
         r1_sel   = rp1;
         flat_sel = 1'b0;
      end else if (t <= fcsc_pkg::CURVE_T2) begin
         t_start  = fcsc_pkg::CURVE_T1;
         r0_sel   = rp1;
         r1_sel   = rp2;
         wide_sel = 1'b1;
         flat_sel = 1'b0;
      end else if (t <= fcsc_pkg::CURVE_T3) begin
         t_start  = fcsc_pkg::CURVE_T2;
         r0_sel   = rp2;
         r1_sel   = rp3;
         wide_sel = 1'b1;
         flat_sel = 1'b0;
      end else if (t <= fcsc_pkg::CURVE_T4) begin
         t_start  = fcsc_pkg::CURVE_T3;
         r0_sel   = rp3;
         r1_sel   = hi18;
         wide_sel = 1'b1;
         flat_sel = 1'b0;
      end else begin
         r0_sel = hi18;
         r1_sel = hi18;
      end
      t_diff  = t - t_start;
      b_dt_in = flat_sel ? 12'd0 : t_diff[11:0];
      b_dr_in = $signed({1'b0, r1_sel}) - $signed({1'b0, r0_sel});
   end

   always_ff @(posedge clock) begin
      if (b_rdy) begin
         b_ctx_ff  <= a_ctx_ff;
         b_dt_ff   <= b_dt_in;
         b_dr_ff   <= b_dr_in;
         b_r0_ff   <= r0_sel;
         b_wide_ff <= wide_sel;
      end
   end

   // ---------------- stage C: (t - t0) * (r1 - r0)
   fcsc_pkg::ctx_type  c_ctx_ff;
   logic signed [12:0] dt_s;
   logic signed [31:0] c_n_in, c_n_ff;
   logic [17:0]        c_r0_ff;
   logic               c_wide_ff;

   assign dt_s   = $signed({1'b0, b_dt_ff});
   assign c_n_in = 32'(dt_s) * 32'(b_dr_ff);

   always_ff @(posedge clock) begin
      if (c_rdy) begin
         c_ctx_ff  <= b_ctx_ff;
         c_n_ff    <= c_n_in;
         c_r0_ff   <= b_r0_ff;
         c_wide_ff <= b_wide_ff;
      end
   end

   // ---------------- stage D: magnitude, round, divide by 256 or 512
   fcsc_pkg::ctx_type c2d_ctx_ff;
   logic [31:0]       n_abs;
   logic [29:0]       rnd;
   logic [21:0]       d_y_in, d_y_ff;
   logic              d_neg_ff;
   logic [17:0]       d_r0_ff;

   always_comb begin
      n_abs  = c_n_ff[31] ? 32'(-c_n_ff) : 32'(c_n_ff);
      rnd    = n_abs[29:0] + (c_wide_ff ? fcsc_pkg::HALF_WIDE : fcsc_pkg::HALF_NARROW);
      d_y_in = c_wide_ff ? {1'b0, rnd[29:9]} : rnd[29:8];
   end

   always_ff @(posedge clock) begin
      if (d_rdy) begin
         c2d_ctx_ff <= c_ctx_ff;
         d_y_ff     <= d_y_in;
         d_neg_ff   <= c_n_ff[31];
         d_r0_ff    <= c_r0_ff;
      end
   end

   // ---------------- stage E: reciprocal multiply, estimate of y / 5
   fcsc_pkg::ctx_type e_ctx_ff;
   logic [41:0]       prod;
   logic [19:0]       e_q0_ff;
   logic [21:0]       e_y_ff;
   logic              e_neg_ff;
   logic [17:0]       e_r0_ff;

   assign prod = 42'(d_y_ff) * 42'(fcsc_pkg::RECIP_FIVE);

   always_ff @(posedge clock) begin
      if (e_rdy) begin
         e_ctx_ff <= c2d_ctx_ff;
         e_q0_ff  <= prod[fcsc_pkg::RECIP_SHIFT +: 20];
         e_y_ff   <= d_y_ff;
         e_neg_ff <= d_neg_ff;
         e_r0_ff  <= d_r0_ff;
      end
   end

   // ---------------- stage F: estimate is low by at most one
   fcsc_pkg::ctx_type f_ctx_ff;
   logic [21:0]       five_q, rem;
   logic [19:0]       f_q_in, f_q_ff;
   logic              f_neg_ff;
   logic [17:0]       f_r0_ff;

   always_comb begin
      five_q = {e_q0_ff, 2'b00} + 22'(e_q0_ff);
      rem    = e_y_ff - five_q;
      f_q_in = (rem >= 22'd5) ? e_q0_ff + 20'd1 : e_q0_ff;
   end

   always_ff @(posedge clock) begin
      if (f_rdy) begin
         f_ctx_ff <= e_ctx_ff;
         f_q_ff   <= f_q_in;
         f_neg_ff <= e_neg_ff;
         f_r0_ff  <= e_r0_ff;
      end
   end

   // ---------------- stage G: add to segment start, clamp to limits
   fcsc_pkg::ctx_type  g_ctx_ff;
   logic signed [20:0] sq, des_raw, lo_s, hi_s;
   logic [16:0]        g_des_in, g_des_ff;

   always_comb begin
      sq      = f_neg_ff ? -$signed({1'b0, f_q_ff}) : $signed({1'b0, f_q_ff});
      des_raw = $signed({3'b000, f_r0_ff}) + sq;
      lo_s    = $signed({4'b0000, f_ctx_ff.lo});
      hi_s    = $signed({4'b0000, f_ctx_ff.hi});
      if (des_raw < lo_s) begin
         des_raw = lo_s;
      end
      if (des_raw > hi_s) begin
         des_raw = hi_s;
      end
      g_des_in = des_raw[16:0];
   end

   always_ff @(posedge clock) begin
      if (g_rdy) begin
         g_ctx_ff <= f_ctx_ff;
         g_des_ff <= g_des_in;
      end
   end

   assign out_valid   = g_v_ff;
   assign out_ctx     = g_ctx_ff;
   assign out_desired = g_des_ff;

endmodule

/* hdl/fan_curve_slew_controller_unit.sv */
// Top level of the fan curve slew controller: csr registers, input register,
// curve pipeline (fcsc_curve), per-fan slew state and result register.
// Uses fcsc_pkg and fcsc_curve.
//
//   channel  dir   handshake               payload
//   req      in    req_valid / req_ready   fan poll transaction, eight fields
//   rsp      out   rsp_valid / rsp_ready   fan number, target, mode, flags
//   csr      in    csr_valid / csr_ready   csr_index, csr_data
//
// One transaction per cycle sustained while rsp_ready is high; each passes from req to rsp
// through the input register, seven curve stages and the result register with slew state.
// Reset is synchronous; it restores register defaults, clears per-fan
// targets and the poll counter. Each stage stalls only when the one behind
// it is full, so bubbles are absorbed. csr_ready is always high.
module fan_curve_slew_controller_unit #(
   parameter int FAN_SLOTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_fan_index,
   input  logic signed [15:0] req_temperature,
   input  logic               req_temperature_ok,
   input  logic [16:0]        req_fan_min_rpm,
   input  logic               req_fan_min_ok,
   input  logic [16:0]        req_fan_max_rpm,
   input  logic               req_fan_max_ok,
   input  logic               req_end_of_poll,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_fan_number,
   output logic [16:0]        rsp_target_rpm,
   output logic               rsp_manual_drive,
   output logic               rsp_target_rejected,
   output logic               rsp_log_now,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [16:0]        csr_data
);

   localparam int IDX_W = (FAN_SLOTS > 1) ? $clog2(FAN_SLOTS) : 1;

   // ---------------- configuration registers
   fcsc_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_rpm         <= fcsc_pkg::RST_BASE_RPM;
         cfg_ff.fallback_min_rpm <= fcsc_pkg::RST_FALLBACK_MIN_RPM;
         cfg_ff.fallback_max_rpm <= fcsc_pkg::RST_FALLBACK_MAX_RPM;
         cfg_ff.hold_band        <= fcsc_pkg::RST_HOLD_BAND;
         cfg_ff.drop_step_cool   <= fcsc_pkg::RST_DROP_STEP_COOL;
         cfg_ff.drop_step_warm   <= fcsc_pkg::RST_DROP_STEP_WARM;
         cfg_ff.drop_switch_temp <= $signed(fcsc_pkg::RST_DROP_SWITCH_TEMP);
      end else if (csr_valid) begin
         case (csr_index)
            fcsc_pkg::CSR_BASE_RPM:         cfg_ff.base_rpm         <= csr_data;
            fcsc_pkg::CSR_FALLBACK_MIN_RPM: cfg_ff.fallback_min_rpm <= csr_data;
            fcsc_pkg::CSR_FALLBACK_MAX_RPM: cfg_ff.fallback_max_rpm <= csr_data;
            fcsc_pkg::CSR_HOLD_BAND:        cfg_ff.hold_band        <= csr_data[11:0];
            fcsc_pkg::CSR_DROP_STEP_COOL:   cfg_ff.drop_step_cool   <= csr_data[11:0];
            fcsc_pkg::CSR_DROP_STEP_WARM:   cfg_ff.drop_step_warm   <= csr_data[11:0];
            fcsc_pkg::CSR_DROP_SWITCH_TEMP: cfg_ff.drop_switch_temp <= $signed(csr_data[15:0]);
            default: ;
         endcase
      end
   end

   // ---------------- input register
   logic               s_valid_ff;
   fcsc_pkg::item_type s_item_ff;
   logic               cur_in_ready;

   assign req_ready = !s_valid_ff || cur_in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         s_item_ff.fan_index      <= req_fan_index;
         s_item_ff.temperature    <= req_temperature;
         s_item_ff.temperature_ok <= req_temperature_ok;
         s_item_ff.fan_min_rpm    <= req_fan_min_rpm;
         s_item_ff.fan_min_ok     <= req_fan_min_ok;
         s_item_ff.fan_max_rpm    <= req_fan_max_rpm;
         s_item_ff.fan_max_ok     <= req_fan_max_ok;
         s_item_ff.end_of_poll    <= req_end_of_poll;
      end
   end

   // ---------------- curve pipeline
   logic              g_valid;
   logic              st_ready;
   fcsc_pkg::ctx_type g_ctx;
   logic [16:0]       g_des;

   fcsc_curve u_curve (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (s_valid_ff),
      .in_ready    (cur_in_ready),
      .in_item     (s_item_ff),
      .out_valid   (g_valid),
      .out_ready   (st_ready),
      .out_ctx     (g_ctx),
      .out_desired (g_des)
   );

   // ---------------- slew state and result register
   logic [16:0] last_target_ff [FAN_SLOTS];
   logic [3:0]  poll_phase_ff;
   logic        rsp_valid_ff;
   logic [3:0]  rsp_fan_number_ff;
   logic [16:0] rsp_target_rpm_ff;
   logic        rsp_manual_drive_ff, rsp_target_rejected_ff, rsp_log_now_ff;

   logic              st_fire;
   logic              in_range;
   logic [IDX_W-1:0]  idx;
   logic [16:0]       last, prev, drop, hold, floor_v, d1, d2, diff1, diff2, w;
   logic              reject, lognow;
   logic [3:0]        phase_in;
   logic [3:0]        out_fan_in;
   logic [16:0]       out_target_in;
   logic              out_manual_in, out_rejected_in, out_log_in;

   assign st_ready = !rsp_valid_ff || rsp_ready;
   assign st_fire  = g_valid && st_ready;
   assign in_range = {1'b0, g_ctx.item.fan_index} < 5'(FAN_SLOTS);
   assign idx      = g_ctx.item.fan_index[IDX_W-1:0];

   always_comb begin
      last = in_range ? last_target_ff[idx] : 17'd0;
      prev = (last != 17'd0) ? last : g_des;
      drop = (g_ctx.item.temperature < cfg_ff.drop_switch_temp) ?
             {5'd0, cfg_ff.drop_step_cool} : {5'd0, cfg_ff.drop_step_warm};
      hold = {5'd0, cfg_ff.hold_band};

      // downward slew limit; prev - drop below zero never binds
      floor_v = prev - drop;
      d1 = g_des;
      if ((g_des < prev) && (prev >= drop) && (floor_v > g_des)) begin
         d1 = floor_v;
      end

      diff1 = (d1 >= prev) ? d1 - prev : prev - d1;
      d2    = ((last != 17'd0) && (diff1 < hold)) ? prev : d1;
      diff2 = (d2 >= last) ? d2 - last : last - d2;
      lognow = (last == 17'd0) || (diff2 >= hold) || (poll_phase_ff == 4'd0);

      // written target clamps to raw limits; stored target does not
      w = d2;
      if (g_ctx.item.fan_min_ok && (w < g_ctx.item.fan_min_rpm)) begin
         w = g_ctx.item.fan_min_rpm;
      end
      if (g_ctx.item.fan_max_ok && (w > g_ctx.item.fan_max_rpm)) begin
         w = g_ctx.item.fan_max_rpm;
      end
      reject = w > fcsc_pkg::REJECT_ABOVE;

      out_fan_in      = g_ctx.item.fan_index;
      out_target_in   = 17'd0;
      out_manual_in   = 1'b0;
      out_rejected_in = 1'b0;
      out_log_in      = 1'b0;
      if (g_ctx.item.temperature_ok) begin
         if (!in_range) begin
            out_rejected_in = 1'b1;
         end else begin
            out_target_in   = w;
            out_manual_in   = 1'b1;
            out_rejected_in = reject;
            out_log_in      = lognow && !reject;
         end
      end

      phase_in = (poll_phase_ff >= fcsc_pkg::PHASE_LAST) ? 4'd0 : poll_phase_ff + 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FAN_SLOTS; i++) begin
            last_target_ff[i] <= 17'd0;
         end
         poll_phase_ff <= 4'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (st_ready) begin
            rsp_valid_ff <= g_valid;
         end
         if (st_fire && g_ctx.item.temperature_ok) begin
            if (in_range && !reject) begin
               last_target_ff[idx] <= d2;
            end
            if (g_ctx.item.end_of_poll) begin
               poll_phase_ff <= phase_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (st_ready) begin
         rsp_fan_number_ff      <= out_fan_in;
         rsp_target_rpm_ff      <= out_target_in;
         rsp_manual_drive_ff    <= out_manual_in;
         rsp_target_rejected_ff <= out_rejected_in;
         rsp_log_now_ff         <= out_log_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_fan_number      = rsp_fan_number_ff;
   assign rsp_target_rpm      = rsp_target_rpm_ff;
   assign rsp_manual_drive    = rsp_manual_drive_ff;
   assign rsp_target_rejected = rsp_target_rejected_ff;
   assign rsp_log_now         = rsp_log_now_ff;

`ifndef NO_ASSERTIONS
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      poll_phase_ff <= fcsc_pkg::PHASE_LAST)
      else $error("poll phase out of range");

   a_phase_moves_on_fire: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (poll_phase_ff != $past(poll_phase_ff))) |->
         $past(st_fire && g_ctx.item.temperature_ok && g_ctx.item.end_of_poll))
      else $error("poll phase changed without a completed poll transaction");

   a_auto_is_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_manual_drive_ff) |->
         (rsp_target_rpm_ff == 17'd0) && !rsp_log_now_ff)
      else $error("automatic-mode result carries a target or log flag");

   a_reject_no_log: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_target_rejected_ff) |-> !rsp_log_now_ff)
      else $error("rejected target flagged for logging");

   a_applied_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_manual_drive_ff && !rsp_target_rejected_ff) |->
         (rsp_target_rpm_ff <= fcsc_pkg::REJECT_ABOVE))
      else $error("applied target above the reject limit");
`endif

endmodule
